/* src/point_set_bounds_and_centroid_assert.svh */
// ----------------------------------------------------------------------------
// point set bounds assertion macros
// concurrent assertion forms shared by the point set bounds modules
// ----------------------------------------------------------------------------
`ifndef POINT_SET_BOUNDS_AND_CENTROID_ASSERT_SVH
`define POINT_SET_BOUNDS_AND_CENTROID_ASSERT_SVH

`ifndef SYNTHESIS

// antecedent implies consequent in the same cycle
`define PSBC_ASSERT_IMPLY(name, ck, rn, ante, cons, msg) \
    name: assert property (@(posedge ck) disable iff (!rn) (ante) |-> (cons)) \
        else $error(msg);

// antecedent implies consequent in the next cycle
`define PSBC_ASSERT_NEXT(name, ck, rn, ante, cons, msg) \
    name: assert property (@(posedge ck) disable iff (!rn) (ante) |=> (cons)) \
        else $error(msg);

// condition never holds
`define PSBC_ASSERT_NEVER(name, ck, rn, cond, msg) \
    name: assert property (@(posedge ck) disable iff (!rn) !(cond)) \
        else $error(msg);

`else

`define PSBC_ASSERT_IMPLY(name, ck, rn, ante, cons, msg)
`define PSBC_ASSERT_NEXT(name, ck, rn, ante, cons, msg)
`define PSBC_ASSERT_NEVER(name, ck, rn, cond, msg)

`endif

`endif

/* src/psbc_pkg.sv */
// ----------------------------------------------------------------------------
// point set bounds package
// item types and axis codes shared by the point set bounds modules
// ----------------------------------------------------------------------------
package psbc_pkg;

    typedef logic [1:0] axis_t;

    localparam axis_t AX_X = 2'd0;
    localparam axis_t AX_Y = 2'd1;
    localparam axis_t AX_Z = 2'd2;

    typedef struct packed {
        logic signed [31:0] coord_x;
        logic signed [31:0] coord_y;
        logic signed [31:0] coord_z;
        logic               set_end;
    } point_t;

    typedef struct packed {
        axis_t              axis;
        logic signed [31:0] low_value;
        logic signed [31:0] high_value;
        logic        [31:0] extent;
        logic signed [31:0] center;
        logic        [15:0] low_index;
        logic        [15:0] high_index;
        logic               overflow;
        logic               last_of_run;
    } result_t;

endpackage

/* src/point_set_bounds_and_centroid.sv */
// one point is taken per cycle while the summary queue has room
// a set's x, y and z results leave one after another after its closing point, computed by
// the shared one-bit-per-cycle divider over SW bits, SW = COORD_WIDTH (at most 32) + count width
// a new set summary waits in a two-entry queue while the divider works on the previous one
// reset is asynchronous, active low, clears all control state at once
// ----------------------------------------------------------------------------
// point set bounds and centroid
// per-axis bounding box, first extreme indices and centroid of point sets
// ----------------------------------------------------------------------------
module point_set_bounds_and_centroid
    import psbc_pkg::*;
#(
    parameter int MAX_POINTS  = 65536,
    parameter int COORD_WIDTH = 32
)
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    point_valid,
    output logic    point_stall,
    input  point_t  point,
    output logic    result_valid,
    input  logic    result_stall,
    output result_t result
);

    localparam int CW = (COORD_WIDTH > 32) ? 32 : COORD_WIDTH;
    localparam int NW = $clog2(MAX_POINTS + 1);
    localparam int SW = CW + NW;
    localparam int QW = 3 * (2 * CW + SW + 32) + NW + 1;

    logic                 q_full;
    logic                 q_push;
    logic [QW-1:0]        q_push_data;
    logic                 q_valid;
    logic                 q_pop;
    logic [QW-1:0]        q_data;
    logic                 div_start;
    logic signed [SW-1:0] div_dividend;
    logic [NW-1:0]        div_divisor;
    logic                 div_busy;
    logic signed [CW-1:0] div_quot;

    psbc_front #(
        .MAX_POINTS (MAX_POINTS),
        .CW         (CW),
        .NW         (NW),
        .SW         (SW),
        .QW         (QW)
    ) u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .point_valid (point_valid),
        .point_stall (point_stall),
        .point       (point),
        .full        (q_full),
        .push        (q_push),
        .push_data   (q_push_data)
    );

    psbc_queue #(
        .W     (QW),
        .DEPTH (2)
    ) u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (q_push),
        .push_data (q_push_data),
        .full      (q_full),
        .pop       (q_pop),
        .valid     (q_valid),
        .data      (q_data)
    );

    psbc_div #(
        .CW (CW),
        .NW (NW),
        .SW (SW)
    ) u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (div_dividend),
        .divisor  (div_divisor),
        .busy     (div_busy),
        .quotient (div_quot)
    );

    psbc_back #(
        .CW (CW),
        .NW (NW),
        .SW (SW),
        .QW (QW)
    ) u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .q_valid      (q_valid),
        .q_data       (q_data),
        .q_pop        (q_pop),
        .div_start    (div_start),
        .div_dividend (div_dividend),
        .div_divisor  (div_divisor),
        .div_busy     (div_busy),
        .div_quot     (div_quot),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .result       (result)
    );

endmodule

/* src/psbc_front.sv */
// ----------------------------------------------------------------------------
// point set bounds front end
// accepts points, tracks per-axis min, max, first indices and sums, and
// pushes a set summary into the queue on the closing point
// ----------------------------------------------------------------------------
module psbc_front
    import psbc_pkg::*;
#(
    parameter int MAX_POINTS = 65536,
    parameter int CW         = 32,
    parameter int NW         = 17,
    parameter int SW         = 49,
    parameter int QW         = 3 * (2 * CW + SW + 32) + NW + 1
)
(
    input  logic          clk,
    input  logic          rst_n,
    input  logic          point_valid,
    output logic          point_stall,
    input  point_t        point,
    input  logic          full,
    output logic          push,
    output logic [QW-1:0] push_data
);

    localparam int AW = 2 * CW + SW + 32;

    logic                 accept;
    logic                 take;
    logic [15:0]          idx;
    logic signed [CW-1:0] v [3];

    logic [NW-1:0]        cnt_reg, cnt_next;
    logic                 ovf_reg, ovf_next;
    logic signed [CW-1:0] min_reg [3];
    logic signed [CW-1:0] min_next [3];
    logic signed [CW-1:0] max_reg [3];
    logic signed [CW-1:0] max_next [3];
    logic signed [SW-1:0] sum_reg [3];
    logic signed [SW-1:0] sum_next [3];
    logic [15:0]          lidx_reg [3];
    logic [15:0]          lidx_next [3];
    logic [15:0]          hidx_reg [3];
    logic [15:0]          hidx_next [3];

    assign point_stall = full;
    assign accept      = point_valid && !full;
    assign push        = accept && point.set_end;

    always_comb
    begin
        take = cnt_reg < NW'(MAX_POINTS);
        idx  = 16'(cnt_reg);
        v[0] = point.coord_x[CW-1:0];
        v[1] = point.coord_y[CW-1:0];
        v[2] = point.coord_z[CW-1:0];
        cnt_next = cnt_reg;
        ovf_next = ovf_reg;
        if (accept)
        begin
            if (take)
            begin
                cnt_next = cnt_reg + NW'(1);
            end
            else
            begin
                ovf_next = 1'b1;
            end
        end
        for (int a = 0; a < 3; a++)
        begin
            min_next[a]  = min_reg[a];
            max_next[a]  = max_reg[a];
            sum_next[a]  = sum_reg[a];
            lidx_next[a] = lidx_reg[a];
            hidx_next[a] = hidx_reg[a];
            if (accept && take)
            begin
                if (cnt_reg == '0)
                begin
                    min_next[a]  = v[a];
                    max_next[a]  = v[a];
                    sum_next[a]  = SW'(v[a]);
                    lidx_next[a] = idx;
                    hidx_next[a] = idx;
                end
                else
                begin
                    if (v[a] < min_reg[a])
                    begin
                        min_next[a]  = v[a];
                        lidx_next[a] = idx;
                    end
                    else if (v[a] > max_reg[a])
                    begin
                        max_next[a]  = v[a];
                        hidx_next[a] = idx;
                    end
                    sum_next[a] = sum_reg[a] + SW'(v[a]);
                end
            end
        end
    end

    always_comb
    begin
        push_data = '0;
        for (int a = 0; a < 3; a++)
        begin
            push_data[a*AW +: CW]                = min_next[a];
            push_data[a*AW + CW +: CW]           = max_next[a];
            push_data[a*AW + 2*CW +: SW]         = sum_next[a];
            push_data[a*AW + 2*CW + SW +: 16]    = lidx_next[a];
            push_data[a*AW + 2*CW + SW + 16 +: 16] = hidx_next[a];
        end
        push_data[3*AW +: NW] = cnt_next;
        push_data[3*AW + NW]  = ovf_next;
    end

    // counters clear on the closing point, payload is rewritten by the next first point
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg <= '0;
            ovf_reg <= 1'b0;
        end
        else if (push)
        begin
            cnt_reg <= '0;
            ovf_reg <= 1'b0;
        end
        else
        begin
            cnt_reg <= cnt_next;
            ovf_reg <= ovf_next;
        end
    end

    always_ff @(posedge clk)
    begin
        for (int a = 0; a < 3; a++)
        begin
            min_reg[a]  <= min_next[a];
            max_reg[a]  <= max_next[a];
            sum_reg[a]  <= sum_next[a];
            lidx_reg[a] <= lidx_next[a];
            hidx_reg[a] <= hidx_next[a];
        end
    end

endmodule

/* src/psbc_queue.sv */
// ----------------------------------------------------------------------------
// point set bounds summary queue
// short queue of set summaries between front end and back end
// ----------------------------------------------------------------------------
`include "point_set_bounds_and_centroid_assert.svh"

module psbc_queue
    import psbc_pkg::*;
#(
    parameter int W     = 32,
    parameter int DEPTH = 2
)
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         push,
    input  logic [W-1:0] push_data,
    output logic         full,
    input  logic         pop,
    output logic         valid,
    output logic [W-1:0] data
);

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int FW = $clog2(DEPTH + 1);

    logic [W-1:0]  slot_reg [DEPTH];
    logic [PW-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [FW-1:0] fill_reg;

    assign full  = fill_reg == FW'(DEPTH);
    assign valid = fill_reg != '0;
    assign data  = slot_reg[rd_ptr_reg];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            fill_reg   <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= (wr_ptr_reg == PW'(DEPTH - 1)) ? '0 : wr_ptr_reg + PW'(1);
            end
            if (pop)
            begin
                rd_ptr_reg <= (rd_ptr_reg == PW'(DEPTH - 1)) ? '0 : rd_ptr_reg + PW'(1);
            end
            if (push && !pop)
            begin
                fill_reg <= fill_reg + FW'(1);
            end
            else if (pop && !push)
            begin
                fill_reg <= fill_reg - FW'(1);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slot_reg[wr_ptr_reg] <= push_data;
        end
    end

    `PSBC_ASSERT_NEVER(a_push_full, clk, rst_n, push && full, "summary pushed into full queue")
    `PSBC_ASSERT_NEVER(a_pop_empty, clk, rst_n, pop && !valid, "summary popped from empty queue")

endmodule

/* src/psbc_div.sv */
// ----------------------------------------------------------------------------
// point set bounds divider
// signed sum over unsigned count, truncated toward zero, one quotient bit
// per cycle
// ----------------------------------------------------------------------------
module psbc_div
    import psbc_pkg::*;
#(
    parameter int CW = 32,
    parameter int NW = 17,
    parameter int SW = 49
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 start,
    input  logic signed [SW-1:0] dividend,
    input  logic [NW-1:0]        divisor,
    output logic                 busy,
    output logic signed [CW-1:0] quotient
);

    localparam int KW = $clog2(SW + 1);

    logic          busy_reg;
    logic [KW-1:0] cnt_reg;
    logic [NW-1:0] rem_reg, rem_next;
    logic [SW-1:0] acc_reg, acc_next;
    logic [NW-1:0] dsr_reg;
    logic          neg_reg;

    logic [SW-1:0] mag;
    logic [NW:0]   trial;
    logic [NW:0]   diff;
    logic          ge;
    logic [SW-1:0] signed_q;

    assign busy = busy_reg;

    always_comb
    begin
        mag      = dividend[SW-1] ? (~unsigned'(dividend) + SW'(1)) : unsigned'(dividend);
        trial    = {rem_reg, acc_reg[SW-1]};
        diff     = trial - {1'b0, dsr_reg};
        ge       = trial >= {1'b0, dsr_reg};
        rem_next = ge ? diff[NW-1:0] : trial[NW-1:0];
        acc_next = {acc_reg[SW-2:0], ge};
        signed_q = neg_reg ? (~acc_reg + SW'(1)) : acc_reg;
        quotient = signed_q[CW-1:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else if (start)
        begin
            busy_reg <= 1'b1;
            cnt_reg  <= KW'(SW);
        end
        else if (busy_reg)
        begin
            cnt_reg <= cnt_reg - KW'(1);
            if (cnt_reg == KW'(1))
            begin
                busy_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            rem_reg <= '0;
            acc_reg <= mag;
            dsr_reg <= divisor;
            neg_reg <= dividend[SW-1];
        end
        else if (busy_reg)
        begin
            rem_reg <= rem_next;
            acc_reg <= acc_next;
        end
    end

endmodule

/* src/psbc_back.sv */
// ----------------------------------------------------------------------------
// point set bounds back end
// takes set summaries from the queue, divides each axis sum by the count
// and sends the x, y and z results through an output register
// ----------------------------------------------------------------------------
`include "point_set_bounds_and_centroid_assert.svh"

module psbc_back
    import psbc_pkg::*;
#(
    parameter int CW = 32,
    parameter int NW = 17,
    parameter int SW = 49,
    parameter int QW = 3 * (2 * CW + SW + 32) + NW + 1
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 q_valid,
    input  logic [QW-1:0]        q_data,
    output logic                 q_pop,
    output logic                 div_start,
    output logic signed [SW-1:0] div_dividend,
    output logic [NW-1:0]        div_divisor,
    input  logic                 div_busy,
    input  logic signed [CW-1:0] div_quot,
    output logic                 result_valid,
    input  logic                 result_stall,
    output result_t              result
);

    localparam int AW = 2 * CW + SW + 32;

    typedef enum logic [1:0] {
        S_IDLE,
        S_DIV,
        S_SEND
    } state_t;

    state_t  state_reg;
    axis_t   axis_reg;
    logic    result_valid_reg;
    result_t result_reg;

    logic signed [CW-1:0] low_a [3];
    logic signed [CW-1:0] high_a [3];
    logic signed [SW-1:0] sum_a [3];
    logic [15:0]          lidx_a [3];
    logic [15:0]          hidx_a [3];
    logic [NW-1:0]        count;
    logic                 ovf;

    logic                 slot_free;
    axis_t                next_axis;
    axis_t                start_axis;
    logic signed [CW-1:0] sel_low, sel_high;
    logic [15:0]          sel_lidx, sel_hidx;
    logic signed [31:0]   low32, high32;
    result_t              item;

    always_comb
    begin
        for (int a = 0; a < 3; a++)
        begin
            low_a[a]  = q_data[a*AW +: CW];
            high_a[a] = q_data[a*AW + CW +: CW];
            sum_a[a]  = q_data[a*AW + 2*CW +: SW];
            lidx_a[a] = q_data[a*AW + 2*CW + SW +: 16];
            hidx_a[a] = q_data[a*AW + 2*CW + SW + 16 +: 16];
        end
        count = q_data[3*AW +: NW];
        ovf   = q_data[3*AW + NW];
    end

    assign slot_free  = !result_valid_reg || !result_stall;
    assign next_axis  = (axis_reg == AX_X) ? AX_Y : AX_Z;
    assign start_axis = (state_reg == S_IDLE) ? AX_X : next_axis;
    assign div_start  = (state_reg == S_IDLE && q_valid)
                     || (state_reg == S_SEND && slot_free && axis_reg != AX_Z);
    assign q_pop      = state_reg == S_SEND && slot_free && axis_reg == AX_Z;
    assign div_divisor = count;

    always_comb
    begin
        case (start_axis)
            AX_X:    div_dividend = sum_a[0];
            AX_Y:    div_dividend = sum_a[1];
            default: div_dividend = sum_a[2];
        endcase
        case (axis_reg)
            AX_X:
            begin
                sel_low  = low_a[0];
                sel_high = high_a[0];
                sel_lidx = lidx_a[0];
                sel_hidx = hidx_a[0];
            end
            AX_Y:
            begin
                sel_low  = low_a[1];
                sel_high = high_a[1];
                sel_lidx = lidx_a[1];
                sel_hidx = hidx_a[1];
            end
            default:
            begin
                sel_low  = low_a[2];
                sel_high = high_a[2];
                sel_lidx = lidx_a[2];
                sel_hidx = hidx_a[2];
            end
        endcase
        low32            = 32'(sel_low);
        high32           = 32'(sel_high);
        item.axis        = axis_reg;
        item.low_value   = low32;
        item.high_value  = high32;
        item.extent      = unsigned'(high32) - unsigned'(low32);
        item.center      = 32'(div_quot);
        item.low_index   = sel_lidx;
        item.high_index  = sel_hidx;
        item.overflow    = ovf;
        item.last_of_run = axis_reg == AX_Z;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= S_IDLE;
            axis_reg         <= AX_X;
            result_valid_reg <= 1'b0;
            result_reg       <= '0;
        end
        else
        begin
            if (state_reg == S_SEND && slot_free)
            begin
                result_valid_reg <= 1'b1;
                result_reg       <= item;
            end
            else if (!result_stall)
            begin
                result_valid_reg <= 1'b0;
            end
            case (state_reg)
                S_IDLE:
                begin
                    if (q_valid)
                    begin
                        axis_reg  <= AX_X;
                        state_reg <= S_DIV;
                    end
                end
                S_DIV:
                begin
                    if (!div_busy)
                    begin
                        state_reg <= S_SEND;
                    end
                end
                S_SEND:
                begin
                    if (slot_free)
                    begin
                        if (axis_reg == AX_Z)
                        begin
                            state_reg <= S_IDLE;
                        end
                        else
                        begin
                            axis_reg  <= next_axis;
                            state_reg <= S_DIV;
                        end
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    assign result_valid = result_valid_reg;
    assign result       = result_reg;

    `PSBC_ASSERT_IMPLY(a_head_held, clk, rst_n, state_reg != S_IDLE, q_valid, "queue head lost during set")
    `PSBC_ASSERT_NEVER(a_restart_busy, clk, rst_n, div_start && div_busy, "divider restarted while busy")
    `PSBC_ASSERT_NEXT(a_pop_sends_z, clk, rst_n, q_pop, result_valid && result.last_of_run, "pop without z result")

endmodule
